// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/firfc_pkg.sv =====
// shared constants and types of the full convolution fir
package firfc_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = $clog2(MAX_TAPS + 1);
    localparam int IDX_BITS    = $clog2(MAX_TAPS);
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int OUT_BITS    = 36;
    localparam int GROUP_SIZE  = 4;
    localparam int NUM_GROUPS  = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_BITS    = PROD_BITS + $clog2(GROUP_SIZE);

    localparam logic [COUNT_BITS-1:0] TAP_COUNT_RESET = COUNT_BITS'(MAX_TAPS);

    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
        logic short_rec;
    } meta_t;

    typedef struct packed {
        logic adv;
        logic shift;
        logic clr;
    } cell_ctrl_t;

endpackage

// ===== rtl/firfc_cell.sv =====
// one tap cell: history sample, coefficient and registered product
module firfc_cell import firfc_pkg::*; (
    input  logic                          aclk,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] din,
    input  logic                          tap_we,
    input  logic signed [SAMPLE_BITS-1:0] tap_din,
    input  logic                          in_use,
    output logic signed [SAMPLE_BITS-1:0] hist,
    output logic signed [PROD_BITS-1:0]   prod
);

    logic signed [SAMPLE_BITS-1:0] hist_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;

    always_comb begin
        prod_next = '0;
        if (in_use) begin
            prod_next = PROD_BITS'(tap_reg) * PROD_BITS'(hist_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            hist_reg <= ctrl.clr ? '0 : din;
        end
        if (tap_we) begin
            tap_reg <= tap_din;
        end
        if (ctrl.adv) begin
            prod_reg <= prod_next;
        end
    end

    assign hist = hist_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/firfc_sum.sv =====
// registered adder tree over the cell products and the output register
module firfc_sum import firfc_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  meta_t                       meta_in,
    input  logic signed [PROD_BITS-1:0] prod [MAX_TAPS],
    output meta_t                       meta_out,
    output logic signed [OUT_BITS-1:0]  filtered
);

    logic signed [GRP_BITS-1:0] grp_reg  [NUM_GROUPS];
    logic signed [GRP_BITS-1:0] grp_next [NUM_GROUPS];
    meta_t                      meta2_reg;
    meta_t                      grp_meta_reg;
    meta_t                      out_meta_reg;
    logic signed [OUT_BITS-1:0] out_reg;
    logic signed [OUT_BITS-1:0] out_next;

    // first level: groups of neighboring cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < MAX_TAPS) begin
                    grp_next[g] = grp_next[g] + GRP_BITS'(prod[g * GROUP_SIZE + k]);
                end
            end
        end
    end

    always_comb begin
        out_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            out_next = out_next + OUT_BITS'(grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                grp_reg[g] <= grp_next[g];
            end
            out_reg <= out_next;
        end
    end

    // meta follows the data: product, group and output stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta2_reg    <= '0;
            grp_meta_reg <= '0;
            out_meta_reg <= '0;
        end else if (adv) begin
            meta2_reg    <= meta_in;
            grp_meta_reg <= meta2_reg;
            out_meta_reg <= grp_meta_reg;
        end
    end

    assign meta_out = out_meta_reg;
    assign filtered = out_reg;

endmodule

// ===== rtl/fir_full_convolution.sv =====
// full linear convolution fir: tap cell chain, adder tree, tail flush control
//
//  channel | direction | ports                                          | handshake
//  s_      | in        | op, sample, sample_last, coef_index, coef_value | s_valid/s_ready
//  m_      | out       | filtered, record_end, short_record             | m_valid/m_ready
//  cfg_    | in        | tap_count                                      | cfg_valid/cfg_ready
//
//  one word per cycle in unless m_ stalls or a tail flushes, one result per cycle out
//  while m_ready is high; samples pass history, product, group and output registers
//  a last sample holds s_ready low while a tail of tap count - 1 zeros is shifted through
//  the cell chain; a stalled m_ side freezes the whole pipeline and holds s_ready low
//  reset is synchronous; history is zeroed on the first shift of each record
module fir_full_convolution import firfc_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_sample_last,
    input  logic        [IDX_BITS-1:0]    s_coef_index,
    input  logic signed [SAMPLE_BITS-1:0] s_coef_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_BITS-1:0]    m_filtered,
    output logic                          m_record_end,
    output logic                          m_short_record,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [COUNT_BITS-1:0]  cfg_tap_count
);

    logic [COUNT_BITS-1:0] tap_count_reg;
    logic                  flush_reg;
    logic [COUNT_BITS-1:0] flush_cnt_reg;
    logic                  short_hold_reg;
    logic [COUNT_BITS-1:0] rec_cnt_reg;
    logic                  clr_pend_reg;
    meta_t                 st0_reg;

    logic                          adv;
    logic                          samp_acc;
    logic                          coef_acc;
    logic [COUNT_BITS-1:0]         t_use;
    logic [COUNT_BITS-1:0]         cnt_inc;
    logic                          shift;
    logic                          final_shift;
    logic                          short_flag;
    logic signed [SAMPLE_BITS-1:0] shift_data;
    meta_t                         meta_out;

    logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
    logic signed [PROD_BITS-1:0]   prod [MAX_TAPS];

    assign adv      = !meta_out.valid || m_ready;
    assign s_ready  = adv && !flush_reg;
    assign samp_acc = s_valid && s_ready && (s_op == OP_SAMPLE);
    assign coef_acc = s_valid && s_ready && (s_op == OP_COEF);

    always_comb begin
        t_use = tap_count_reg;
        if (tap_count_reg == '0) begin
            t_use = COUNT_BITS'(1);
        end else if (tap_count_reg > COUNT_BITS'(MAX_TAPS)) begin
            t_use = COUNT_BITS'(MAX_TAPS);
        end
    end

    assign cnt_inc = (rec_cnt_reg == COUNT_BITS'(MAX_TAPS)) ? rec_cnt_reg
                                                            : rec_cnt_reg + COUNT_BITS'(1);

    assign shift      = samp_acc || (flush_reg && adv);
    assign shift_data = flush_reg ? '0 : s_sample;

    always_comb begin
        final_shift = 1'b0;
        short_flag  = 1'b0;
        if (flush_reg) begin
            final_shift = adv && (flush_cnt_reg == COUNT_BITS'(1));
            short_flag  = short_hold_reg;
        end else if (samp_acc) begin
            final_shift = s_sample_last && (t_use == COUNT_BITS'(1));
            short_flag  = cnt_inc < t_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg  <= TAP_COUNT_RESET;
            flush_reg      <= 1'b0;
            flush_cnt_reg  <= '0;
            short_hold_reg <= 1'b0;
            rec_cnt_reg    <= '0;
            clr_pend_reg   <= 1'b1;
            st0_reg        <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tap_count_reg <= cfg_tap_count;
            end
            if (samp_acc) begin
                rec_cnt_reg <= s_sample_last ? '0 : cnt_inc;
                if (s_sample_last && (t_use != COUNT_BITS'(1))) begin
                    flush_reg      <= 1'b1;
                    flush_cnt_reg  <= t_use - COUNT_BITS'(1);
                    short_hold_reg <= cnt_inc < t_use;
                end
            end else if (flush_reg && adv) begin
                flush_cnt_reg <= flush_cnt_reg - COUNT_BITS'(1);
                if (final_shift) begin
                    flush_reg <= 1'b0;
                end
            end
            // the next record starts from a clear history
            if (shift) begin
                clr_pend_reg <= final_shift;
            end
            if (adv) begin
                st0_reg.valid     <= shift;
                st0_reg.last      <= final_shift;
                st0_reg.short_rec <= final_shift && short_flag;
            end
        end
    end

    assign cfg_ready = 1'b1;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        cell_ctrl_t                    ctrl;
        logic                          clr;
        logic signed [SAMPLE_BITS-1:0] din;

        if (j == 0) begin : g_head
            assign clr = 1'b0;
            assign din = shift_data;
        end else begin : g_body
            assign clr = clr_pend_reg;
            assign din = hist[j-1];
        end
        assign ctrl = '{adv: adv, shift: shift, clr: clr};

        firfc_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .din     (din),
            .tap_we  (coef_acc && (s_coef_index == IDX_BITS'(j))),
            .tap_din (s_coef_value),
            .in_use  (COUNT_BITS'(j) < t_use),
            .hist    (hist[j]),
            .prod    (prod[j])
        );
    end

    firfc_sum u_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .meta_in  (st0_reg),
        .prod     (prod),
        .meta_out (meta_out),
        .filtered (m_filtered)
    );

    assign m_valid        = meta_out.valid;
    assign m_record_end   = meta_out.last;
    assign m_short_record = meta_out.short_rec;

endmodule

// ===== rtl/firfc_checker.sv =====
// port-level checks of the full convolution fir and their binding
`include "assert_macros.svh"

module firfc_checker import firfc_pkg::*; (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [OUT_BITS-1:0]    m_filtered,
    input logic                          m_record_end,
    input logic                          m_short_record
);

    // a stalled word holds its value
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_filtered))

    // short flag only rides on the final word of a record
    `ASSERT_CLK(a_short_on_end, aclk, aresetn, m_valid && m_short_record |-> m_record_end)

    // a blocked output freezes the pipeline, so no new word is taken
    `ASSERT_CLK(a_stall_blocks_in, aclk, aresetn, m_valid && !m_ready |-> !s_ready)

    // nothing is shown in the cycle after a reset edge
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind fir_full_convolution firfc_checker u_firfc_checker (.*);

// ===== dv/fir_full_convolution_test.sv =====
// self-checking testbench for the full linear convolution fir
`timescale 1ns / 1ps

module fir_full_convolution_test;
    import firfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TARGET_WORDS   = 410;

    typedef struct {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic        [IDX_BITS-1:0]    idx;
        logic signed [SAMPLE_BITS-1:0] coef;
    } word_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       record_end;
        logic                       short_record;
    } conv_out_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_op = OP_COEF;
    logic signed [SAMPLE_BITS-1:0] s_sample = '0;
    logic                          s_sample_last = 1'b0;
    logic        [IDX_BITS-1:0]    s_coef_index = '0;
    logic signed [SAMPLE_BITS-1:0] s_coef_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [OUT_BITS-1:0]    m_filtered;
    logic                          m_record_end;
    logic                          m_short_record;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic        [COUNT_BITS-1:0]  cfg_tap_count = TAP_COUNT_RESET;

    fir_full_convolution DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_sample       (s_sample),
        .s_sample_last  (s_sample_last),
        .s_coef_index   (s_coef_index),
        .s_coef_value   (s_coef_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_filtered     (m_filtered),
        .m_record_end   (m_record_end),
        .m_short_record (m_short_record),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_tap_count  (cfg_tap_count)
    );

    // predictor state
    logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
    int unsigned                   rec_samples = 0;
    logic        [COUNT_BITS-1:0]  tap_cfg = TAP_COUNT_RESET;

    word_t       pending_words [$];
    conv_out_t   filtered_q [$];
    int unsigned words_queued = 0;
    int unsigned words_accepted = 0;
    int unsigned errors = 0;
    int unsigned src_max_gap = 0;
    int unsigned snk_max_gap = 0;
    int unsigned src_gap_left = 0;
    int unsigned snk_stall_left = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned effective_taps();
        if (tap_cfg == 0)
            return 1;
        if (tap_cfg > MAX_TAPS)
            return MAX_TAPS;
        return int'(tap_cfg);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] push_history(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        logic signed [63:0] acc;
        int unsigned        t;
        acc = '0;
        t = effective_taps();
        for (int j = MAX_TAPS - 1; j > 0; j--)
            hist[j] = hist[j-1];
        hist[0] = x;
        for (int j = 0; j < t; j++)
            acc += 64'(coef_mem[j]) * 64'(hist[j]);
        return acc[OUT_BITS-1:0];
    endfunction

    // expected results of one accepted word
    task automatic convolve_word(
        input logic                          op,
        input logic signed [SAMPLE_BITS-1:0] sample,
        input logic                          last,
        input logic        [IDX_BITS-1:0]    idx,
        input logic signed [SAMPLE_BITS-1:0] coef
    );
        conv_out_t   res;
        int unsigned t;
        if (op == OP_COEF) begin
            coef_mem[idx] = coef;
            return;
        end
        if (rec_samples < MAX_TAPS)
            rec_samples++;
        res.filtered = push_history(sample);
        res.record_end = 1'b0;
        res.short_record = 1'b0;
        if (last) begin
            t = effective_taps();
            // tail of zeros through the history
            for (int k = 1; k < t; k++) begin
                filtered_q.insert(filtered_q.size(), res);
                res.filtered = push_history('0);
            end
            res.record_end = 1'b1;
            res.short_record = (rec_samples < t);
            for (int j = 0; j < MAX_TAPS; j++)
                hist[j] = '0;
            rec_samples = 0;
        end
        filtered_q.insert(filtered_q.size(), res);
    endtask

    // driver
    always @(posedge aclk) begin : driver
        int unsigned gap;
        word_t       w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap_left <= 0;
        end else begin
            gap = src_gap_left;
            if (s_valid && s_ready) begin
                convolve_word(s_op, s_sample, s_sample_last, s_coef_index, s_coef_value);
                words_accepted++;
                gap = $urandom_range(0, src_max_gap);
            end
            if (s_valid && !s_ready) begin
                // hold the word until accepted
            end else if (gap != 0) begin
                s_valid <= 1'b0;
                src_gap_left <= gap - 1;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                s_op <= w.op;
                s_sample <= w.sample;
                s_sample_last <= w.last;
                s_coef_index <= w.idx;
                s_coef_value <= w.coef;
                s_valid <= 1'b1;
                src_gap_left <= 0;
            end else begin
                s_valid <= 1'b0;
                src_gap_left <= 0;
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : monitor
        int unsigned stall;
        conv_out_t   exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_stall_left <= 0;
        end else begin
            stall = snk_stall_left;
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: filtered %0d end %0b short %0b",
                                 m_filtered, m_record_end, m_short_record);
                end else begin
                    exp_res = filtered_q.pop_front();
                    if (m_filtered !== exp_res.filtered
                        || m_record_end !== exp_res.record_end
                        || m_short_record !== exp_res.short_record) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     exp_res.filtered, exp_res.record_end,
                                     exp_res.short_record, m_filtered,
                                     m_record_end, m_short_record);
                    end
                end
                stall = $urandom_range(0, snk_max_gap);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                snk_stall_left <= stall - 1;
            end else begin
                m_ready <= 1'b1;
                snk_stall_left <= 0;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("fir_full_convolution_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic last);
        word_t w;
        w.op = OP_SAMPLE;
        w.sample = v;
        w.last = last;
        w.idx = IDX_BITS'($urandom);
        w.coef = SAMPLE_BITS'($urandom);
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    task automatic queue_coef(input logic [IDX_BITS-1:0] i,
                              input logic signed [SAMPLE_BITS-1:0] v);
        word_t w;
        w.op = OP_COEF;
        w.sample = SAMPLE_BITS'($urandom);
        w.last = 1'($urandom);
        w.idx = i;
        w.coef = v;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    // all words taken, all results out, then a settle time for the pipeline
    task automatic wait_idle();
        do @(posedge aclk);
        while (words_accepted != words_queued || filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tap_count(input logic [COUNT_BITS-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_tap_count <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        tap_cfg = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return SAMPLE_BITS'(-32768);
            1: return SAMPLE_BITS'(32767);
            2: return '0;
            3: return SAMPLE_BITS'(-1);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned rec_left;
        int unsigned phase_len;
        int unsigned n;
        int unsigned r;
        logic [COUNT_BITS-1:0] tc;
        rec_left = 0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            coef_mem[j] = '0;
            hist[j] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset tap count: full store of extreme taps, then a short record
        for (int j = 0; j < MAX_TAPS; j++)
            queue_coef(IDX_BITS'(j), (j == MAX_TAPS - 1) ? 16'sd32767 : -16'sd32768);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd32767, 1'b1);

        // zero tap count behaves as one tap
        write_tap_count('0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(-16'sd1, 1'b1);

        // tap count above the store size, single-sample record
        write_tap_count(COUNT_BITS'(31));
        queue_coef(IDX_BITS'(3), 16'sd32767);
        queue_sample(16'sd32767, 1'b1);

        // random phases; records may be cut by a tap count change
        n = 0;
        while (words_queued < TARGET_WORDS) begin
            r = $urandom_range(0, 9);
            case (r)
                0: tc = '0;
                1: tc = COUNT_BITS'(1);
                2: tc = COUNT_BITS'(MAX_TAPS);
                3: tc = COUNT_BITS'(31);
                4: tc = COUNT_BITS'($urandom_range(MAX_TAPS + 1, 31));
                default: tc = COUNT_BITS'($urandom_range(1, MAX_TAPS));
            endcase
            write_tap_count(tc);
            src_max_gap = (n % 3 == 0) ? 0 : 15;
            snk_max_gap = (n % 4 == 1) ? 0 : 15;
            phase_len = $urandom_range(10, 40);
            for (int i = 0; i < phase_len && words_queued < TARGET_WORDS; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_coef(IDX_BITS'($urandom), pick_value());
                end else begin
                    if (rec_left == 0) begin
                        if ($urandom_range(0, 3) == 0)
                            rec_left = $urandom_range(1, effective_taps());
                        else
                            rec_left = $urandom_range(1, 24);
                    end
                    queue_sample(pick_value(), rec_left == 1);
                    rec_left--;
                end
            end
            n++;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && filtered_q.size() == 0) begin
            $display("fir_full_convolution_test OK");
        end else begin
            $display("fir_full_convolution_test NOT OK");
        end
        $finish;
    end

endmodule
